@@ hw/rtl/fdnr_pkg.sv @@
// Shared types, constants and helper functions of the Newton-Raphson float divider.
`default_nettype none

package fdnr_pkg;

  // Float field layout
  localparam int unsigned FP_W  = 32;
  localparam int unsigned EXP_W = 8;
  localparam int unsigned FRAC_W = 23;
  localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'hFF;
  localparam logic [EXP_W-1:0] EXP_HALF     = 8'd126;
  localparam logic [EXP_W-1:0] EXP_ONE      = 8'd127;
  localparam int unsigned QUIET_IDX = 22;
  localparam logic [FP_W-1:0] ONE_WORD  = 32'h3F80_0000;
  localparam logic [FP_W-1:0] QNAN_WORD = 32'h7FC0_0000;

  // Seed constants as double significands: 32/17 = K1 * 2^-52, 48/17 = K2 * 2^-51
  localparam logic [52:0] SEED_MUL = 53'h1E1E1E1E1E1E1E;
  localparam logic [52:0] SEED_ADD = 53'h16969696969697;
  localparam int unsigned SEED_LO_W = 27;
  localparam int unsigned SEED_HI_W = 53 - SEED_LO_W;

  // Unit depths
  localparam int unsigned FMUL_LAT = 4;
  localparam int unsigned FADD_LAT = 5;

  localparam int unsigned REFINE_STEPS_DEF = 3;

  // Sideband that rides along with the reciprocal
  typedef struct packed {
    logic            nan;  // scaled dividend is a NaN, bypass the arithmetic
    logic [FP_W-1:0] n2;   // scaled dividend
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  typedef struct packed {
    logic [FP_W-1:0] x;
    logic [FP_W-1:0] d2;
    side_t           side;
  } step_tag_t;

  localparam int unsigned STEP_TAG_W = $bits(step_tag_t);

  // Leading zero count of a 27-bit word, 27 when zero
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    n = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (v[i]) n = 5'(26 - i);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fdnr_fmul.sv @@
// Four-stage single-precision multiplier, round to nearest even, with sideband tag.
`default_nettype none

module fdnr_fmul #(
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [31:0]      p_o,
  output logic [TAG_W-1:0] tag_o
);
  import fdnr_pkg::*;

  logic [FMUL_LAT-1:0] vld_q;
  logic [TAG_W-1:0]    tag_q [FMUL_LAT];

  // Stage 1: unpack, normalize subnormals, specials
  logic                sa, sb;
  logic [EXP_W-1:0]    efa, efb;
  logic [FRAC_W-1:0]   fra, frb;
  logic [23:0]         ma_raw, mb_raw;
  logic [4:0]          lz_a, lz_b;
  logic a_zero, b_zero, a_inf, b_inf, a_nan, b_nan;
  logic                s1_spec_d;
  logic [31:0]         s1_word_d;

  always_comb begin
    sa  = a_i[31];
    sb  = b_i[31];
    efa = a_i[30:23];
    efb = b_i[30:23];
    fra = a_i[22:0];
    frb = b_i[22:0];
    ma_raw = {efa != '0, fra};
    mb_raw = {efb != '0, frb};
    lz_a = lzc27({ma_raw, 3'b111});
    lz_b = lzc27({mb_raw, 3'b111});
    a_zero = (efa == '0) && (fra == '0);
    b_zero = (efb == '0) && (frb == '0);
    a_inf  = (efa == EXP_ALL_ONES) && (fra == '0);
    b_inf  = (efb == EXP_ALL_ONES) && (frb == '0);
    a_nan  = (efa == EXP_ALL_ONES) && (fra != '0);
    b_nan  = (efb == EXP_ALL_ONES) && (frb != '0);
    s1_spec_d = 1'b1;
    s1_word_d = {sa ^ sb, 31'd0};
    priority if (a_nan) begin
      s1_word_d = a_i;
      s1_word_d[QUIET_IDX] = 1'b1;
    end else if (b_nan) begin
      s1_word_d = b_i;
      s1_word_d[QUIET_IDX] = 1'b1;
    end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
      s1_word_d = QNAN_WORD;
    end else if (a_inf || b_inf) begin
      s1_word_d = {sa ^ sb, EXP_ALL_ONES, 23'd0};
    end else if (a_zero || b_zero) begin
      s1_word_d = {sa ^ sb, 31'd0};
    end else begin
      s1_spec_d = 1'b0;
    end
  end

  logic               s1_sign_q, s1_spec_q;
  logic [31:0]        s1_word_q;
  logic [23:0]        s1_ma_q, s1_mb_q;
  logic signed [9:0]  s1_ea_q, s1_eb_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= sa ^ sb;
      s1_spec_q <= s1_spec_d;
      s1_word_q <= s1_word_d;
      s1_ma_q   <= 24'(ma_raw << lz_a);
      s1_mb_q   <= 24'(mb_raw << lz_b);
      s1_ea_q   <= (efa == '0) ? (10'sd1 - $signed({5'd0, lz_a})) : $signed({2'd0, efa});
      s1_eb_q   <= (efb == '0) ? (10'sd1 - $signed({5'd0, lz_b})) : $signed({2'd0, efb});
    end
  end

  // Stage 2: significand product and raw exponent
  logic               s2_sign_q, s2_spec_q;
  logic [31:0]        s2_word_q;
  logic [47:0]        s2_prod_q;
  logic signed [9:0]  s2_exp_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_spec_q <= s1_spec_q;
      s2_word_q <= s1_word_q;
      s2_prod_q <= 48'(s1_ma_q * s1_mb_q);
      s2_exp_q  <= s1_ea_q + s1_eb_q - 10'sd127;
    end
  end

  // Stage 3: normalize, denormalize on underflow, round decision
  logic [47:0]        norm, shq, mask;
  logic signed [9:0]  be, shs;
  logic [4:0]         sh;
  logic               stk, rnd, s3_inc_d, s3_ovf_d;
  logic [30:0]        s3_packed_d;

  always_comb begin
    norm = s2_prod_q[47] ? s2_prod_q : {s2_prod_q[46:0], 1'b0};
    be   = s2_exp_q + $signed({9'd0, s2_prod_q[47]});
    shs  = 10'sd1 - be;
    sh   = 5'd0;
    if (be < 10'sd1) begin
      sh = (shs > 10'sd25) ? 5'd25 : shs[4:0];
    end
    mask = ~({48{1'b1}} << sh);
    shq  = norm >> sh;
    stk  = |(norm & mask);
    rnd  = shq[23];
    s3_inc_d    = rnd & (stk | (|shq[22:0]) | shq[24]);
    s3_ovf_d    = (be >= 10'sd255);
    s3_packed_d = {(be >= 10'sd1) ? be[7:0] : 8'd0, shq[46:24]};
  end

  logic        s3_sign_q, s3_spec_q, s3_inc_q, s3_ovf_q;
  logic [31:0] s3_word_q;
  logic [30:0] s3_packed_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sign_q   <= s2_sign_q;
      s3_spec_q   <= s2_spec_q;
      s3_word_q   <= s2_word_q;
      s3_inc_q    <= s3_inc_d;
      s3_ovf_q    <= s3_ovf_d;
      s3_packed_q <= s3_packed_d;
    end
  end

  // Stage 4: round and pack; a carry into the exponent makes infinity by itself
  logic [31:0] s4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (s3_spec_q) begin
        s4_q <= s3_word_q;
      end else if (s3_ovf_q) begin
        s4_q <= {s3_sign_q, EXP_ALL_ONES, 23'd0};
      end else begin
        s4_q <= {s3_sign_q, s3_packed_q + {30'd0, s3_inc_q}};
      end
    end
  end

  // Valid bits and tag travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FMUL_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < FMUL_LAT; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  assign valid_o = vld_q[FMUL_LAT-1];
  assign p_o     = s4_q;
  assign tag_o   = tag_q[FMUL_LAT-1];

endmodule

`default_nettype wire

@@ hw/rtl/fdnr_fadd.sv @@
// Five-stage single-precision adder, round to nearest even, with sideband tag.
`default_nettype none

module fdnr_fadd #(
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [31:0]      s_o,
  output logic [TAG_W-1:0] tag_o
);
  import fdnr_pkg::*;

  logic [FADD_LAT-1:0] vld_q;
  logic [TAG_W-1:0]    tag_q [FADD_LAT];

  // Stage 1: unpack, order by magnitude, specials
  logic [31:0]      big, sml;
  logic [EXP_W-1:0] eb_eff, es_eff, diff;
  logic a_inf, b_inf, a_nan, b_nan;
  logic             s1_spec_d;
  logic [31:0]      s1_word_d;

  always_comb begin
    big = (a_i[30:0] >= b_i[30:0]) ? a_i : b_i;
    sml = (a_i[30:0] >= b_i[30:0]) ? b_i : a_i;
    eb_eff = (big[30:23] == '0) ? 8'd1 : big[30:23];
    es_eff = (sml[30:23] == '0) ? 8'd1 : sml[30:23];
    diff   = eb_eff - es_eff;
    a_inf  = (a_i[30:23] == EXP_ALL_ONES) && (a_i[22:0] == '0);
    b_inf  = (b_i[30:23] == EXP_ALL_ONES) && (b_i[22:0] == '0);
    a_nan  = (a_i[30:23] == EXP_ALL_ONES) && (a_i[22:0] != '0);
    b_nan  = (b_i[30:23] == EXP_ALL_ONES) && (b_i[22:0] != '0);
    s1_spec_d = 1'b1;
    s1_word_d = a_i;
    priority if (a_nan) begin
      s1_word_d[QUIET_IDX] = 1'b1;
    end else if (b_nan) begin
      s1_word_d = b_i;
      s1_word_d[QUIET_IDX] = 1'b1;
    end else if (a_inf && b_inf && (a_i[31] != b_i[31])) begin
      s1_word_d = QNAN_WORD;
    end else if (a_inf) begin
      s1_word_d = a_i;
    end else if (b_inf) begin
      s1_word_d = b_i;
    end else begin
      s1_spec_d = 1'b0;
    end
  end

  logic             s1_sign_q, s1_sub_q, s1_zs_q, s1_spec_q;
  logic [31:0]      s1_word_q;
  logic [EXP_W-1:0] s1_exp_q;
  logic [23:0]      s1_mbig_q, s1_msml_q;
  logic [4:0]       s1_sh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= big[31];
      s1_sub_q  <= a_i[31] ^ b_i[31];
      s1_zs_q   <= a_i[31] & b_i[31];
      s1_spec_q <= s1_spec_d;
      s1_word_q <= s1_word_d;
      s1_exp_q  <= eb_eff;
      s1_mbig_q <= {big[30:23] != '0, big[22:0]};
      s1_msml_q <= {sml[30:23] != '0, sml[22:0]};
      s1_sh_q   <= (diff > 8'd27) ? 5'd27 : diff[4:0];
    end
  end

  // Stage 2: align the smaller operand, keep guard, round and sticky
  logic [26:0] ext, al, amask;
  logic        astk;

  always_comb begin
    ext   = {s1_msml_q, 3'b000};
    al    = ext >> s1_sh_q;
    amask = ~({27{1'b1}} << s1_sh_q);
    astk  = |(ext & amask);
  end

  logic             s2_sign_q, s2_sub_q, s2_zs_q, s2_spec_q;
  logic [31:0]      s2_word_q;
  logic [EXP_W-1:0] s2_exp_q;
  logic [26:0]      s2_big_q, s2_sml_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_sub_q  <= s1_sub_q;
      s2_zs_q   <= s1_zs_q;
      s2_spec_q <= s1_spec_q;
      s2_word_q <= s1_word_q;
      s2_exp_q  <= s1_exp_q;
      s2_big_q  <= {s1_mbig_q, 3'b000};
      s2_sml_q  <= {al[26:1], al[0] | astk};
    end
  end

  // Stage 3: add or subtract magnitudes
  logic             s3_sign_q, s3_zs_q, s3_spec_q;
  logic [31:0]      s3_word_q;
  logic [EXP_W-1:0] s3_exp_q;
  logic [27:0]      s3_sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_sign_q <= s2_sign_q;
      s3_zs_q   <= s2_zs_q;
      s3_spec_q <= s2_spec_q;
      s3_word_q <= s2_word_q;
      s3_exp_q  <= s2_exp_q;
      s3_sum_q  <= s2_sub_q ? ({1'b0, s2_big_q} - {1'b0, s2_sml_q})
                            : ({1'b0, s2_big_q} + {1'b0, s2_sml_q});
    end
  end

  // Stage 4: normalize, left shift limited so the exponent stays at least one
  logic [4:0]       lz, nsh;
  logic [EXP_W-1:0] lim;
  logic [26:0]      nrm;
  logic [8:0]       ne;
  logic             s4_ovf_d, s4_inc_d;

  always_comb begin
    lz  = lzc27(s3_sum_q[26:0]);
    lim = s3_exp_q - 8'd1;
    nsh = ({3'd0, lz} > lim) ? lim[4:0] : lz;
    if (s3_sum_q[27]) begin
      nrm = {s3_sum_q[27:2], s3_sum_q[1] | s3_sum_q[0]};
      ne  = {1'b0, s3_exp_q} + 9'd1;
    end else begin
      nrm = s3_sum_q[26:0] << nsh;
      ne  = {1'b0, s3_exp_q} - {4'd0, nsh};
    end
    s4_ovf_d = (ne >= 9'd255);
    s4_inc_d = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
  end

  logic        s4_sign_q, s4_zs_q, s4_spec_q, s4_zero_q, s4_ovf_q, s4_inc_q;
  logic [31:0] s4_word_q;
  logic [30:0] s4_packed_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_sign_q   <= s3_sign_q;
      s4_zs_q     <= s3_zs_q;
      s4_spec_q   <= s3_spec_q;
      s4_word_q   <= s3_word_q;
      s4_zero_q   <= (s3_sum_q == '0);
      s4_ovf_q    <= s4_ovf_d;
      s4_inc_q    <= s4_inc_d;
      s4_packed_q <= {nrm[26] ? ne[7:0] : 8'd0, nrm[25:3]};
    end
  end

  // Stage 5: round and pack
  logic [31:0] s5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      priority if (s4_spec_q) begin
        s5_q <= s4_word_q;
      end else if (s4_zero_q) begin
        s5_q <= {s4_zs_q, 31'd0};
      end else if (s4_ovf_q) begin
        s5_q <= {s4_sign_q, EXP_ALL_ONES, 23'd0};
      end else begin
        s5_q <= {s4_sign_q, s4_packed_q + {30'd0, s4_inc_q}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FADD_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < FADD_LAT; i++) tag_q[i] <= tag_q[i-1];
    end
  end

  assign valid_o = vld_q[FADD_LAT-1];
  assign s_o     = s5_q;
  assign tag_o   = tag_q[FADD_LAT-1];

endmodule

`default_nettype wire

@@ hw/rtl/fdnr_seed.sv @@
// Operand scaling and reciprocal seed 48/17 - 32/17*d, formed in exact double steps.
`default_nettype none

module fdnr_seed (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     dividend_i,
  input  logic [31:0]     divisor_i,
  output logic            valid_o,
  output logic [31:0]     x_o,
  output logic [31:0]     d2_o,
  output fdnr_pkg::side_t side_o
);
  import fdnr_pkg::*;

  localparam int unsigned SEED_LAT = 6;

  logic [SEED_LAT-1:0] vld_q;
  logic [31:0]         d2_q   [SEED_LAT];
  side_t               side_q [SEED_LAT];

  // Stage 1: scaled dividend, NaN check, partial products of the seed slope
  logic signed [9:0] mexp;
  logic              sx;
  side_t             side_d;
  logic [23:0]       mden;

  always_comb begin
    sx   = dividend_i[31] ^ divisor_i[31];
    mexp = $signed({2'd0, dividend_i[30:23]}) + $signed({2'd0, EXP_HALF})
         - $signed({2'd0, divisor_i[30:23]});
    side_d.nan = 1'b0;
    if (mexp[8]) begin
      // exponent wrapped: negative shift gives zero, otherwise infinity
      side_d.n2 = (mexp < 10'sd0) ? {sx, 31'd0} : {sx, EXP_ALL_ONES, 23'd0};
    end else begin
      side_d.n2  = {sx, mexp[7:0], dividend_i[22:0]};
      side_d.nan = (mexp[7:0] == EXP_ALL_ONES) && (dividend_i[22:0] != '0);
    end
    mden = {1'b1, divisor_i[22:0]};
  end

  logic [SEED_HI_W+23:0] s1_ph_q;
  logic [SEED_LO_W+23:0] s1_pl_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ph_q <= (SEED_HI_W+24)'(mden * SEED_MUL[52:SEED_LO_W]);
      s1_pl_q <= (SEED_LO_W+24)'(mden * SEED_MUL[SEED_LO_W-1:0]);
    end
  end

  // Stage 2: full 77-bit product
  logic [76:0] s2_p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_p_q <= ({27'd0, s1_ph_q} << SEED_LO_W) + {26'd0, s1_pl_q};
    end
  end

  // Stage 3: round product to a double, align to 2^-53
  logic [52:0] pk;
  logic        pr, ps;
  logic [53:0] pq;

  always_comb begin
    if (s2_p_q[76]) begin
      pk = s2_p_q[76:24];
      pr = s2_p_q[23];
      ps = |s2_p_q[22:0];
    end else begin
      pk = s2_p_q[75:23];
      pr = s2_p_q[22];
      ps = |s2_p_q[21:0];
    end
    pq = {1'b0, pk} + {53'd0, pr & (ps | pk[0])};
  end

  logic [54:0] s3_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_d_q <= s2_p_q[76] ? {pq, 1'b0} : {1'b0, pq};
    end
  end

  // Stage 4: exact difference 48/17 - product
  logic [54:0] s4_diff_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_diff_q <= {SEED_ADD, 2'b00} - s3_d_q;
    end
  end

  // Stage 5: round difference to a double
  logic [52:0] s5_m_q;
  logic        s5_sel_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_sel_q <= s4_diff_q[53];
      s5_m_q   <= s4_diff_q[53] ? (s4_diff_q[53:1] + {52'd0, s4_diff_q[0] & s4_diff_q[1]})
                                : s4_diff_q[52:0];
    end
  end

  // Stage 6: round double to single
  logic        xinc;
  logic [30:0] xbase;

  always_comb begin
    xinc  = s5_m_q[28] & ((|s5_m_q[27:0]) | s5_m_q[29]);
    xbase = {s5_sel_q ? EXP_ONE : EXP_HALF, s5_m_q[51:29]};
  end

  logic [31:0] s6_x_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_x_q <= {1'b0, xbase + {30'd0, xinc}};
    end
  end

  // Valid bits and sidebands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[SEED_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d2_q[0]   <= {1'b0, EXP_HALF, divisor_i[22:0]};
      side_q[0] <= side_d;
      for (int i = 1; i < SEED_LAT; i++) begin
        d2_q[i]   <= d2_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[SEED_LAT-1];
  assign x_o     = s6_x_q;
  assign d2_o    = d2_q[SEED_LAT-1];
  assign side_o  = side_q[SEED_LAT-1];

endmodule

`default_nettype wire

@@ hw/rtl/fdnr_step.sv @@
// One refinement step x + x*(1 - d*x), four pipelined float operations.
`default_nettype none

module fdnr_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     x_i,
  input  logic [31:0]     d2_i,
  input  fdnr_pkg::side_t side_i,
  output logic            valid_o,
  output logic [31:0]     x_o,
  output logic [31:0]     d2_o,
  output fdnr_pkg::side_t side_o
);
  import fdnr_pkg::*;

  step_tag_t   tag0, tag1, tag2, tag3;
  logic        v1, v2, v3;
  logic [31:0] t_w, e_w, c_w;

  assign tag0 = '{x: x_i, d2: d2_i, side: side_i};

  // t = d*x
  fdnr_fmul #(.TAG_W(STEP_TAG_W)) u_mul_t (
    .clk_i, .rst_ni, .en_i,
    .valid_i(valid_i), .a_i(d2_i), .b_i(x_i), .tag_i(tag0),
    .valid_o(v1), .p_o(t_w), .tag_o(tag1)
  );

  // e = 1 - t
  fdnr_fadd #(.TAG_W(STEP_TAG_W)) u_add_e (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v1), .a_i(ONE_WORD), .b_i({~t_w[31], t_w[30:0]}), .tag_i(tag1),
    .valid_o(v2), .s_o(e_w), .tag_o(tag2)
  );

  // c = x*e
  fdnr_fmul #(.TAG_W(STEP_TAG_W)) u_mul_c (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v2), .a_i(tag2.x), .b_i(e_w), .tag_i(tag2),
    .valid_o(v3), .p_o(c_w), .tag_o(tag3)
  );

  // x + c
  step_tag_t tag4;

  fdnr_fadd #(.TAG_W(STEP_TAG_W)) u_add_x (
    .clk_i, .rst_ni, .en_i,
    .valid_i(v3), .a_i(tag3.x), .b_i(c_w), .tag_i(tag3),
    .valid_o(valid_o), .s_o(x_o), .tag_o(tag4)
  );

  assign d2_o   = tag4.d2;
  assign side_o = tag4.side;

endmodule

`default_nettype wire

@@ hw/rtl/float_divide_newton_raphson_core.sv @@
// Single-precision divider: seed, Newton-Raphson refinement and final multiply.
//
// Input channel: valid_i/stall_o with dividend_i and divisor_i (IEEE-754 single
// bit patterns); a word is taken at a clock edge with valid_i high, stall_o low.
// Output channel: valid_o/stall_i with quotient_o, taken when stall_i is low.
// The divisor is scaled into [0.5,1), the dividend exponent moved to match, a
// seed formed from a linear fit, refined REFINE_STEPS times and multiplied in.
// The pipeline has 6 seed stages, 18 per refinement step (two 4-stage
// multipliers and two 5-stage adders) and 5 for the final multiplier and
// the output register. Throughput: one word per cycle while the output is
// not stalled; every stage is a register with a valid bit.
// When the receiver stalls a waiting quotient, the whole pipeline holds and
// one more input word is still taken into a skid register; stall_o rises
// only while that register is occupied and drops the cycle the output moves.
// Reset (rst_ni low, asynchronous) clears all valid bits and the skid
// register; words in flight are dropped. No clearing pass is needed.
`default_nettype none

module float_divide_newton_raphson_core #(
  parameter int unsigned REFINE_STEPS = fdnr_pkg::REFINE_STEPS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] quotient_o
);
  import fdnr_pkg::*;

  logic        en;
  logic        out_vld_q;
  logic [31:0] out_q;
  logic        skid_vld_q;
  logic [31:0] skid_dvd_q, skid_dvs_q;
  logic        accept;
  logic        pipe_v;
  logic [31:0] pipe_dvd, pipe_dvs;

  // Pipeline advances unless a finished word is held at the output
  assign en     = !(out_vld_q && stall_i);
  assign accept = valid_i && !skid_vld_q;
  assign pipe_v   = skid_vld_q || accept;
  assign pipe_dvd = skid_vld_q ? skid_dvd_q : dividend_i;
  assign pipe_dvs = skid_vld_q ? skid_dvs_q : divisor_i;

  // Skid register: holds one word taken while the pipeline is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (accept) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && accept) begin
      skid_dvd_q <= dividend_i;
      skid_dvs_q <= divisor_i;
    end
  end

  // Seed
  logic        v_w    [REFINE_STEPS+1];
  logic [31:0] x_w    [REFINE_STEPS+1];
  logic [31:0] d2_w   [REFINE_STEPS+1];
  side_t       side_w [REFINE_STEPS+1];

  fdnr_seed u_seed (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pipe_v), .dividend_i(pipe_dvd), .divisor_i(pipe_dvs),
    .valid_o(v_w[0]), .x_o(x_w[0]), .d2_o(d2_w[0]), .side_o(side_w[0])
  );

  // Refinement chain
  for (genvar gi = 0; gi < REFINE_STEPS; gi++) begin : g_step
    fdnr_step u_step (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(v_w[gi]), .x_i(x_w[gi]), .d2_i(d2_w[gi]), .side_i(side_w[gi]),
      .valid_o(v_w[gi+1]), .x_o(x_w[gi+1]), .d2_o(d2_w[gi+1]), .side_o(side_w[gi+1])
    );
  end

  // Final multiply by the scaled dividend
  logic        fin_v;
  logic [31:0] fin_p;
  side_t       fin_side;
  logic [31:0] fin_word;

  fdnr_fmul #(.TAG_W(SIDE_W)) u_mul_q (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v_w[REFINE_STEPS]), .a_i(side_w[REFINE_STEPS].n2), .b_i(x_w[REFINE_STEPS]),
    .tag_i(side_w[REFINE_STEPS]),
    .valid_o(fin_v), .p_o(fin_p), .tag_o(fin_side)
  );

  // NaN dividend after scaling passes through quieted
  always_comb begin
    fin_word = fin_p;
    if (fin_side.nan) begin
      fin_word = fin_side.n2;
      fin_word[QUIET_IDX] = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= fin_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= fin_word;
    end
  end

  assign stall_o    = skid_vld_q;
  assign valid_o    = out_vld_q;
  assign quotient_o = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/fdnr_checker.sv @@
// Port-level checks of the divider's handshakes, bound to the top level.
`default_nettype none

module fdnr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] quotient_o
);

  // A stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(quotient_o))
    else $error("stalled output word dropped or changed");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !valid_o && !stall_o)
    else $error("output valid or input stall right after reset");

  // Input stall only rises when a word arrived while the output was held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_i && valid_o && stall_i))
    else $error("input stall raised without a held output");

  // Skid word drains as soon as the output moves
  a_stall_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o && !(valid_o && stall_i) |=> !stall_o)
    else $error("input stall held after output moved");

endmodule

bind float_divide_newton_raphson_core fdnr_checker u_fdnr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (valid_i),
  .stall_o    (stall_o),
  .valid_o    (valid_o),
  .stall_i    (stall_i),
  .quotient_o (quotient_o)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of the Newton-Raphson single-precision divider.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdnr_pkg::*;

  localparam int unsigned STEPS = REFINE_STEPS_DEF;
  localparam int unsigned PIPE_LAT = 18 * STEPS + 11;
  localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
  localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
  localparam logic [31:0] FRAC_MASK = 32'h007F_FFFF;
  localparam logic [31:0] HALF_EXP_WORD = 32'h3F00_0000;
  localparam int unsigned RANDOM_WORDS = 1730;

  logic        clk;
  logic        rst_n;
  logic        valid_in;
  logic        stall_out;
  logic [31:0] dividend;
  logic [31:0] divisor;
  logic        valid_out;
  logic        stall_in;
  logic [31:0] quotient;

  logic [31:0] quotient_q[$];
  int          err_cnt;
  logic        stall_seen;
  int          burst_left;
  int          hold_req;
  int          stall_pct;
  int          pct_timer;

  float_divide_newton_raphson_core #(
    .REFINE_STEPS(STEPS)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .valid_i   (valid_in),
    .stall_o   (stall_out),
    .dividend_i(dividend),
    .divisor_i (divisor),
    .valid_o   (valid_out),
    .stall_i   (stall_in),
    .quotient_o(quotient)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Round mag * 2^scale to a single, nearest-even, with subnormals and overflow
  function automatic logic [31:0] round_single(input logic s, input logic [127:0] mag,
                                               input int scale);
    int p;
    int rsh;
    int be;
    logic [127:0] kept;
    logic [127:0] rem;
    logic [127:0] half;
    if (mag == '0) return {s, 31'b0};
    p = 0;
    for (int i = 0; i < 128; i++) if (mag[i]) p = i;
    rsh = p - 23;
    if (rsh < -149 - scale) rsh = -149 - scale;
    if (rsh > 120) return {s, 31'b0};
    if (rsh > 0) begin
      kept = mag >> rsh;
      rem = mag - (kept << rsh);
      half = 128'd1 << (rsh - 1);
      if (rem > half || (rem == half && kept[0])) kept = kept + 1;
    end else begin
      kept = mag << (-rsh);
    end
    if (kept[24]) begin
      kept = kept >> 1;
      rsh++;
    end
    if (kept[23]) begin
      be = rsh + scale + 150;
      if (be >= 255) return {s, EXP_ALL_ONES, 23'b0};
      return {s, be[7:0], kept[22:0]};
    end
    return {s, 8'h00, kept[22:0]};
  endfunction

  function automatic logic [23:0] mant_of(input logic [31:0] f);
    return {(f[30:23] != 8'h00), f[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] f);
    return (f[30:23] == 8'h00) ? 1 : int'(f[30:23]);
  endfunction

  function automatic logic is_nan(input logic [31:0] f);
    return f[30:23] == EXP_ALL_ONES && f[22:0] != '0;
  endfunction

  function automatic logic is_inf(input logic [31:0] f);
    return f[30:23] == EXP_ALL_ONES && f[22:0] == '0;
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == '0;
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNAN_WORD;
    if (is_inf(a) || is_inf(b)) begin
      if (is_zero(a) || is_zero(b)) return QNAN_WORD;
      return {s, EXP_ALL_ONES, 23'b0};
    end
    if (is_zero(a) || is_zero(b)) return {s, 31'b0};
    return round_single(s, 128'(mant_of(a)) * 128'(mant_of(b)), exp_of(a) + exp_of(b) - 300);
  endfunction

  function automatic logic [31:0] sp_add(input logic [31:0] a_in, input logic [31:0] b_in);
    logic [31:0] a;
    logic [31:0] b;
    logic [127:0] big;
    logic [127:0] mag;
    logic s;
    int d;
    if (is_nan(a_in) || is_nan(b_in)) return QNAN_WORD;
    if (is_inf(a_in) && is_inf(b_in) && a_in[31] != b_in[31]) return QNAN_WORD;
    if (is_inf(a_in)) return a_in;
    if (is_inf(b_in)) return b_in;
    if (is_zero(a_in) && is_zero(b_in)) return {a_in[31] & b_in[31], 31'b0};
    if (is_zero(a_in)) return b_in;
    if (is_zero(b_in)) return a_in;
    // a takes the larger exponent
    if (exp_of(a_in) >= exp_of(b_in)) begin
      a = a_in;
      b = b_in;
    end else begin
      a = b_in;
      b = a_in;
    end
    d = exp_of(a) - exp_of(b);
    if (d > 50) return a;
    big = 128'(mant_of(a)) << d;
    if (a[31] == b[31]) begin
      mag = big + 128'(mant_of(b));
      s = a[31];
    end else if (big >= 128'(mant_of(b))) begin
      mag = big - 128'(mant_of(b));
      s = a[31];
    end else begin
      mag = 128'(mant_of(b)) - big;
      s = b[31];
    end
    if (mag == '0) return 32'h0;
    return round_single(s, mag, exp_of(b) - 150);
  endfunction

  // Expected quotient bits for one operand pair
  function automatic logic [31:0] divide_nr(input logic [31:0] num, input logic [31:0] den);
    logic [31:0] shift;
    logic [31:0] moved;
    logic [31:0] d2;
    logic [31:0] n2;
    logic [31:0] x;
    logic [63:0] db;
    real d2r;
    real seed;
    shift = HALF_EXP_WORD - (den & EXP_MASK);
    moved = (num & EXP_MASK) + shift;
    d2 = (den & FRAC_MASK) | HALF_EXP_WORD;
    if (moved[31]) begin
      if (shift[31]) n2 = (num & SIGN_MASK) ^ (den & SIGN_MASK);
      else n2 = ((num & SIGN_MASK) | EXP_MASK) ^ (den & SIGN_MASK);
    end else begin
      n2 = ((num & ~EXP_MASK) | moved) ^ (den & SIGN_MASK);
    end
    if (is_nan(n2)) return n2 | (32'h1 << QUIET_IDX);
    // seed in double, rounded once to single
    d2r = $bitstoreal({1'b0, 11'd1022, d2[22:0], 29'b0});
    seed = (48.0 / 17.0) - (32.0 / 17.0) * d2r;
    db = $realtobits(seed);
    x = round_single(db[63], 128'({1'b1, db[51:0]}), int'(db[62:52]) - 1075);
    for (int k = 0; k < STEPS; k++) begin
      x = sp_add(x, sp_mul(x, sp_add(ONE_WORD, sp_mul(d2, x) ^ SIGN_MASK)));
    end
    return sp_mul(n2, x);
  endfunction

  // Stall as the block shows it just before the next rising edge
  always @(negedge clk) stall_seen <= stall_out;

  // Input monitor: predict every accepted word
  always @(posedge clk) begin
    if (rst_n && valid_in && !stall_out) quotient_q.push_back(divide_nr(dividend, divisor));
  end

  // Output checker
  always @(posedge clk) begin
    logic [31:0] exp_q;
    if (rst_n && valid_out && !stall_in) begin
      if (quotient_q.size() == 0) begin
        $error("unexpected quotient word %h", quotient);
        err_cnt++;
      end else begin
        exp_q = quotient_q.pop_front();
        if (quotient !== exp_q) begin
          $error("quotient: expected %h actual %h (%h / %h)", exp_q, quotient,
                 dividend, divisor);
          err_cnt++;
        end
      end
    end
  end

  // Receiver stall pattern, plus a long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      stall_in <= 1'b0;
      pct_timer <= 0;
      stall_pct <= 0;
    end else begin
      if (pct_timer == 0) begin
        pct_timer <= $urandom_range(50, 300);
        case ($urandom_range(0, 3))
          0: stall_pct <= 0;
          1: stall_pct <= 20;
          2: stall_pct <= 50;
          default: stall_pct <= 80;
        endcase
      end else begin
        pct_timer <= pct_timer - 1;
      end
      if (hold_req > 0) begin
        stall_in <= 1'b1;
        hold_req <= hold_req - 1;
      end else begin
        stall_in <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Send one word; sender idles in random bursts
  task automatic send_word(input logic [31:0] num, input logic [31:0] den);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        valid_in <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    valid_in <= 1'b1;
    dividend <= num;
    divisor <= den;
    @(posedge clk);
    while (stall_seen) @(posedge clk);
  endtask

  function automatic logic [31:0] make_float(input logic s, input logic [7:0] e);
    return {s, e, 23'($urandom)};
  endfunction

  task automatic test_directed();
    send_word(32'h3F80_0000, 32'h3F80_0000);  // 1 / 1
    send_word(32'h4040_0000, 32'h4000_0000);  // 3 / 2
    send_word(32'hC0A0_0000, 32'h4040_0000);  // sign xor
    send_word(32'h4000_0000, 32'hBF7F_FFFF);
    send_word(32'h0000_0000, 32'h3F80_0000);  // zero dividend
    send_word(32'h8000_0000, 32'h0000_0000);  // zero by zero
    send_word(32'h3F80_0000, 32'h0000_0000);  // zero divisor
    send_word(32'h7F80_0000, 32'h3F80_0000);  // infinite dividend
    send_word(32'h3F80_0000, 32'h7F80_0000);  // infinite divisor
    send_word(32'h7FC0_0001, 32'h3F80_0000);  // NaN dividend
    send_word(32'h7F80_0001, 32'h3F00_0000);  // signaling NaN stays NaN
    send_word(32'h3F80_0000, 32'hFFFF_FFFF);  // NaN divisor
    send_word(32'h0000_0001, 32'h3F80_0000);  // subnormal dividend
    send_word(32'h007F_FFFF, 32'h0040_0000);  // subnormal both
    send_word(32'h3F80_0000, 32'h0000_0001);  // subnormal divisor
    send_word(32'h0080_0000, 32'h7F7F_FFFF);  // exponent underflow
    send_word(32'h8100_0000, 32'h7E80_0000);  // underflow, negative
    send_word(32'h7F7F_FFFF, 32'h0080_0000);  // exponent overflow
    send_word(32'hFF7F_FFFF, 32'h8000_0000);  // overflow, sign xor
    send_word(32'h7F00_0000, 32'h3E80_0000);  // lands on all-ones exponent
    send_word(32'h7F12_3456, 32'h3E80_0000);  // lands on NaN
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'h0000_0000, 32'h0000_0000);
    send_word(32'h3F7F_FFFF, 32'h3F7F_FFFF);
  endtask

  task automatic test_random(input int unsigned count);
    logic [7:0] de;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_word($urandom, $urandom);
        3: begin
          // exponents drawn over the full range
          de = 8'($urandom_range(0, 255));
          send_word(make_float(1'($urandom), 8'($urandom_range(0, 255))),
                    make_float(1'($urandom), de));
        end
        4: send_word(make_float(1'($urandom), 8'($urandom_range(0, 3))),
                     make_float(1'($urandom), 8'($urandom_range(100, 150))));
        5: send_word(make_float(1'($urandom), 8'($urandom_range(200, 255))),
                     make_float(1'($urandom), 8'($urandom_range(0, 60))));
        default: send_word(make_float(1'($urandom), 8'($urandom_range(90, 160))),
                           make_float(1'($urandom), 8'($urandom_range(90, 160))));
      endcase
    end
  endtask

  // Receiver holds off long enough to fill the pipeline and stall the input
  task automatic test_backpressure();
    hold_req = 4 * PIPE_LAT;
    burst_left = 1000;
    for (int i = 0; i < 3 * PIPE_LAT; i++) send_word($urandom, $urandom);
    burst_left = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    valid_in = 1'b0;
    dividend = '0;
    divisor = '0;
    err_cnt = 0;
    burst_left = 0;
    hold_req = 0;
    stall_seen = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(RANDOM_WORDS / 2);
    test_backpressure();
    test_random(RANDOM_WORDS / 2);
    valid_in <= 1'b0;
    while (quotient_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
